FILE: src/pwrb_pkg.sv
package pwrb_pkg;

  // table geometry (SLOTS is a power of two: slot index is a bit slice)
  localparam int CONTEXTS    = 8;
  localparam int SLOTS       = 16;
  localparam int HANDLE_BITS = 16;
  localparam int SEQ_BITS    = 24;
  localparam int CTX_BITS    = $clog2(CONTEXTS);
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int ADDR_BITS   = CTX_BITS + SLOT_BITS;
  localparam int ENTRIES     = CONTEXTS * SLOTS;

  localparam logic [SEQ_BITS-1:0] SEQ_MASK = 24'hFF_FFFF;

  // slot status codes
  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_RECV = 2'd2;

  typedef logic [SEQ_BITS-1:0]    seq_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;

  typedef enum logic [1:0] {
    CMD_ADD, CMD_QUERY, CMD_READ, CMD_REMOVE
  } cmd_t;

  typedef enum logic [1:0] {
    SEG_FIRST, SEG_MIDDLE, SEG_LAST, SEG_ONLY
  } seg_kind_t;

  typedef enum logic [3:0] {
    RES_ACCEPTED, RES_DUP, RES_FULL, RES_NOT_FOUND, RES_QUERY,
    RES_ORDERED, RES_INCOMPLETE, RES_RELEASED, RES_REMOVED
  } res_kind_t;

  typedef enum logic [1:0] {
    ASEL_PSN, ASEL_EXP, ASEL_ROW
  } addr_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_ADD_RD, S_ADD_CHK, S_GAP_RD, S_GAP_CHK, S_ACCEPT,
    S_Q_RD, S_Q_CHK, S_RD1_RD, S_RD1_CHK, S_RD2_RD, S_RD2_CHK,
    S_RM_RD, S_RM_CHK, S_RM_END
  } state_t;

  // one slot memory word
  typedef struct packed {
    logic [1:0] status;
    seg_kind_t  kind;
    handle_t    handle;
  } slot_word_t;

  localparam int WORD_BITS = $bits(slot_word_t);

  // controller -> datapath
  typedef struct packed {
    logic      latch_in;
    logic      ctx_pick;
    logic      ctx_alloc;
    logic      ctx_free;
    logic      addr_ld;
    addr_sel_t addr_sel;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      end_ld;
    logic      wr_recv;
    logic      wr_wait;
    logic      emit;
    res_kind_t emit_kind;
    logic      emit_final;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic hit;
    logic free_any;
    logic out_full;
    logic st_recv;
    logic st_free;
    logic kind_last;
    logic dist_zero;
    logic dist_small;
    logic cnt_nxt_eq_dist;
    logic cnt_last;
    logic cnt_eq_end;
  } dp_stat_t;

endpackage

FILE: src/pwrb_ram.sv
module pwrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/pwrb_ctrl.sv
module pwrb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pwrb_pkg::dp_stat_t stat,
  output pwrb_pkg::ctl_cmd_t cmd
);

  pwrb_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pwrb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.addr_sel   = pwrb_pkg::ASEL_PSN;
    cmd.emit_kind  = pwrb_pkg::RES_ACCEPTED;
    unique case (state_r)
      pwrb_pkg::S_IDLE: begin
        // no item is taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.latch_in = 1'b1;
          state_nxt    = pwrb_pkg::S_LOOKUP;
        end
      end
      pwrb_pkg::S_LOOKUP: begin
        cmd.cnt_clr = 1'b1;
        if (stat.cmd == pwrb_pkg::CMD_ADD) begin
          priority if (stat.hit) begin
            cmd.ctx_pick = 1'b1;
            state_nxt    = pwrb_pkg::S_ADD_RD;
          end else if (stat.free_any) begin
            cmd.ctx_alloc = 1'b1;
            state_nxt     = pwrb_pkg::S_ADD_RD;
          end else if (!stat.out_full) begin
            cmd.emit       = 1'b1;
            cmd.emit_kind  = pwrb_pkg::RES_FULL;
            cmd.emit_final = 1'b1;
            state_nxt      = pwrb_pkg::S_IDLE;
          end
        end else if (!stat.hit) begin
          if (!stat.out_full) begin
            cmd.emit       = 1'b1;
            cmd.emit_kind  = pwrb_pkg::RES_NOT_FOUND;
            cmd.emit_final = 1'b1;
            state_nxt      = pwrb_pkg::S_IDLE;
          end
        end else begin
          cmd.ctx_pick = 1'b1;
          unique case (stat.cmd)
            pwrb_pkg::CMD_QUERY: state_nxt = pwrb_pkg::S_Q_RD;
            pwrb_pkg::CMD_READ:  state_nxt = pwrb_pkg::S_RD1_RD;
            default:             state_nxt = pwrb_pkg::S_RM_RD;
          endcase
        end
      end
      pwrb_pkg::S_ADD_RD: begin
        cmd.addr_ld  = 1'b1;
        cmd.addr_sel = pwrb_pkg::ASEL_PSN;
        state_nxt    = pwrb_pkg::S_ADD_CHK;
      end
      pwrb_pkg::S_ADD_CHK: begin
        if (stat.st_recv) begin
          if (!stat.out_full) begin
            cmd.emit       = 1'b1;
            cmd.emit_kind  = pwrb_pkg::RES_DUP;
            cmd.emit_final = 1'b1;
            state_nxt      = pwrb_pkg::S_IDLE;
          end
        end else begin
          cmd.wr_recv = 1'b1;
          if (stat.dist_zero || !stat.dist_small) begin
            state_nxt = pwrb_pkg::S_ACCEPT;
          end else begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = pwrb_pkg::S_GAP_RD;
          end
        end
      end
      pwrb_pkg::S_GAP_RD: begin
        cmd.addr_ld  = 1'b1;
        cmd.addr_sel = pwrb_pkg::ASEL_EXP;
        state_nxt    = pwrb_pkg::S_GAP_CHK;
      end
      pwrb_pkg::S_GAP_CHK: begin
        cmd.wr_wait = stat.st_free;
        cmd.cnt_inc = 1'b1;
        state_nxt   = stat.cnt_nxt_eq_dist ? pwrb_pkg::S_ACCEPT : pwrb_pkg::S_GAP_RD;
      end
      pwrb_pkg::S_ACCEPT: begin
        if (!stat.out_full) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = pwrb_pkg::RES_ACCEPTED;
          cmd.emit_final = 1'b1;
          state_nxt      = pwrb_pkg::S_IDLE;
        end
      end
      pwrb_pkg::S_Q_RD: begin
        cmd.addr_ld  = 1'b1;
        cmd.addr_sel = pwrb_pkg::ASEL_EXP;
        state_nxt    = pwrb_pkg::S_Q_CHK;
      end
      pwrb_pkg::S_Q_CHK: begin
        if (!stat.out_full) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = pwrb_pkg::RES_QUERY;
          cmd.emit_final = 1'b1;
          state_nxt      = pwrb_pkg::S_IDLE;
        end
      end
      // first pass: check the run is whole
      pwrb_pkg::S_RD1_RD: begin
        cmd.addr_ld  = 1'b1;
        cmd.addr_sel = pwrb_pkg::ASEL_ROW;
        state_nxt    = pwrb_pkg::S_RD1_CHK;
      end
      pwrb_pkg::S_RD1_CHK: begin
        priority if (!stat.st_recv) begin
          if (!stat.out_full) begin
            cmd.emit       = 1'b1;
            cmd.emit_kind  = pwrb_pkg::RES_INCOMPLETE;
            cmd.emit_final = 1'b1;
            state_nxt      = pwrb_pkg::S_IDLE;
          end
        end else if (stat.kind_last || stat.cnt_last) begin
          cmd.end_ld  = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = pwrb_pkg::S_RD2_RD;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = pwrb_pkg::S_RD1_RD;
        end
      end
      // second pass: deliver handles
      pwrb_pkg::S_RD2_RD: begin
        cmd.addr_ld  = 1'b1;
        cmd.addr_sel = pwrb_pkg::ASEL_ROW;
        state_nxt    = pwrb_pkg::S_RD2_CHK;
      end
      pwrb_pkg::S_RD2_CHK: begin
        if (!stat.out_full) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = pwrb_pkg::RES_ORDERED;
          cmd.emit_final = stat.cnt_eq_end;
          cmd.cnt_inc    = !stat.cnt_eq_end;
          state_nxt      = stat.cnt_eq_end ? pwrb_pkg::S_IDLE : pwrb_pkg::S_RD2_RD;
        end
      end
      pwrb_pkg::S_RM_RD: begin
        cmd.addr_ld  = 1'b1;
        cmd.addr_sel = pwrb_pkg::ASEL_ROW;
        state_nxt    = pwrb_pkg::S_RM_CHK;
      end
      pwrb_pkg::S_RM_CHK: begin
        if (!(stat.st_recv && stat.out_full)) begin
          cmd.emit      = stat.st_recv;
          cmd.emit_kind = pwrb_pkg::RES_RELEASED;
          cmd.cnt_inc   = !stat.cnt_last;
          state_nxt     = stat.cnt_last ? pwrb_pkg::S_RM_END : pwrb_pkg::S_RM_RD;
        end
      end
      pwrb_pkg::S_RM_END: begin
        if (!stat.out_full) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = pwrb_pkg::RES_REMOVED;
          cmd.emit_final = 1'b1;
          cmd.ctx_free   = 1'b1;
          state_nxt      = pwrb_pkg::S_IDLE;
        end
      end
      default: state_nxt = pwrb_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: src/pwrb_dp.sv
module pwrb_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [63:0]                         in_tdata,
  input  logic [3:0]                          in_tuser,
  input  pwrb_pkg::ctl_cmd_t                  cmd,
  output pwrb_pkg::dp_stat_t                  stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [47:0]                         out_tdata,
  output logic [3:0]                          out_tuser,
  output logic                                out_tlast
);

  // latched item
  pwrb_pkg::cmd_t      cmd_r;
  pwrb_pkg::seq_t      qp_r, psn_r;
  pwrb_pkg::seg_kind_t kind_r;
  pwrb_pkg::handle_t   hdl_r;

  // context table
  logic [pwrb_pkg::CONTEXTS-1:0] ctx_valid_r;
  pwrb_pkg::seq_t                ctx_qp_r    [pwrb_pkg::CONTEXTS];
  pwrb_pkg::seq_t                ctx_first_r [pwrb_pkg::CONTEXTS];
  pwrb_pkg::seq_t                ctx_exp_r   [pwrb_pkg::CONTEXTS];
  logic [pwrb_pkg::CONTEXTS-1:0] ctx_done_r;

  logic [pwrb_pkg::CTX_BITS-1:0]  cur_r;
  logic [pwrb_pkg::ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [pwrb_pkg::SLOT_BITS-1:0] cnt_r, end_r;
  logic [pwrb_pkg::ENTRIES-1:0]   vbit_r, vbit_nxt;

  // output register
  logic                 out_valid_r;
  pwrb_pkg::res_kind_t  o_kind_r;
  pwrb_pkg::handle_t    o_hdl_r;
  logic                 o_final_r, o_done_r, o_gap_r;
  pwrb_pkg::seq_t       o_gseq_r;

  logic [pwrb_pkg::CTX_BITS-1:0]  hit_idx, free_idx;
  logic                           hit, free_any;
  pwrb_pkg::seq_t                 cur_first, cur_exp, psn_dist, slot_d;
  logic [pwrb_pkg::SLOT_BITS-1:0] slot_idx;
  logic                           ram_we;
  pwrb_pkg::slot_word_t           ram_wdata, ram_rdata;
  logic [1:0]                     st_eff;

  // context match and free search, lowest index wins
  always_comb begin
    hit      = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = pwrb_pkg::CONTEXTS - 1; i >= 0; i--) begin
      if (ctx_valid_r[i] && ctx_qp_r[i] == qp_r) begin
        hit     = 1'b1;
        hit_idx = pwrb_pkg::CTX_BITS'(i);
      end
      if (!ctx_valid_r[i]) begin
        free_any = 1'b1;
        free_idx = pwrb_pkg::CTX_BITS'(i);
      end
    end
  end

  assign cur_first = ctx_first_r[cur_r];
  assign cur_exp   = ctx_exp_r[cur_r];
  assign psn_dist  = (psn_r - cur_exp) & pwrb_pkg::SEQ_MASK;

  // slot address select
  always_comb begin
    unique case (cmd.addr_sel)
      pwrb_pkg::ASEL_PSN: slot_d = psn_r - cur_first;
      pwrb_pkg::ASEL_EXP: slot_d = cur_exp + pwrb_pkg::seq_t'(cnt_r) - cur_first;
      default:            slot_d = pwrb_pkg::seq_t'(cnt_r);
    endcase
    slot_idx = slot_d[pwrb_pkg::SLOT_BITS-1:0];
    addr_nxt = cmd.addr_ld ? {cur_r, slot_idx} : addr_r;
  end

  // slot memory write
  always_comb begin
    ram_we    = cmd.wr_recv | cmd.wr_wait;
    ram_wdata.handle = hdl_r;
    if (cmd.wr_recv) begin
      ram_wdata.status = pwrb_pkg::ST_RECV;
      ram_wdata.kind   = kind_r;
    end else begin
      ram_wdata.status = pwrb_pkg::ST_WAIT;
      ram_wdata.kind   = pwrb_pkg::SEG_FIRST;
    end
  end

  pwrb_ram #(
    .WIDTH (pwrb_pkg::WORD_BITS),
    .DEPTH (pwrb_pkg::ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .raddr (addr_nxt),
    .rdata (ram_rdata)
  );

  // an entry without its valid bit reads as free
  assign st_eff = vbit_r[addr_r] ? ram_rdata.status : pwrb_pkg::ST_FREE;

  // slot valid bits
  always_comb begin
    vbit_nxt = vbit_r;
    if (ram_we) begin
      vbit_nxt[addr_r] = 1'b1;
    end
    if (cmd.ctx_alloc) begin
      for (int j = 0; j < pwrb_pkg::SLOTS; j++) begin
        vbit_nxt[{free_idx, pwrb_pkg::SLOT_BITS'(j)}] = 1'b0;
      end
    end
    if (cmd.ctx_free) begin
      for (int j = 0; j < pwrb_pkg::SLOTS; j++) begin
        vbit_nxt[{cur_r, pwrb_pkg::SLOT_BITS'(j)}] = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_valid_r <= '0;
      vbit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vbit_r <= vbit_nxt;
      if (cmd.ctx_alloc) begin
        ctx_valid_r[free_idx] <= 1'b1;
      end
      if (cmd.ctx_free) begin
        ctx_valid_r[cur_r] <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      qp_r   <= in_tdata[23:0];
      psn_r  <= in_tdata[47:24];
      hdl_r  <= in_tdata[63:48];
      cmd_r  <= pwrb_pkg::cmd_t'(in_tuser[1:0]);
      kind_r <= pwrb_pkg::seg_kind_t'(in_tuser[3:2]);
    end
    if (cmd.ctx_pick) begin
      cur_r <= hit_idx;
    end
    if (cmd.ctx_alloc) begin
      cur_r                 <= free_idx;
      ctx_qp_r[free_idx]    <= qp_r;
      ctx_first_r[free_idx] <= psn_r;
      ctx_exp_r[free_idx]   <= psn_r;
      ctx_done_r[free_idx]  <= 1'b0;
    end
    if (cmd.wr_recv) begin
      if (psn_dist == '0) begin
        ctx_exp_r[cur_r] <= (cur_exp + 1'b1) & pwrb_pkg::SEQ_MASK;
      end
      if (kind_r == pwrb_pkg::SEG_LAST || kind_r == pwrb_pkg::SEG_ONLY) begin
        ctx_done_r[cur_r] <= 1'b1;
      end
    end
    addr_r <= addr_nxt;
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.end_ld) begin
      end_r <= cnt_r;
    end
    if (cmd.emit) begin
      o_kind_r  <= cmd.emit_kind;
      o_final_r <= cmd.emit_final;
      o_done_r  <= 1'b0;
      o_gap_r   <= 1'b0;
      o_gseq_r  <= '0;
      unique case (cmd.emit_kind)
        pwrb_pkg::RES_DUP:                        o_hdl_r <= hdl_r;
        pwrb_pkg::RES_ORDERED, pwrb_pkg::RES_RELEASED: o_hdl_r <= ram_rdata.handle;
        default:                                  o_hdl_r <= '0;
      endcase
      if (cmd.emit_kind == pwrb_pkg::RES_QUERY) begin
        o_done_r <= ctx_done_r[cur_r];
        o_gap_r  <= st_eff != pwrb_pkg::ST_RECV;
        o_gseq_r <= (st_eff != pwrb_pkg::ST_RECV) ? cur_exp : '0;
      end
    end
  end

  // status to controller
  always_comb begin
    stat.cmd             = cmd_r;
    stat.hit             = hit;
    stat.free_any        = free_any;
    stat.out_full        = out_valid_r && !out_tready;
    stat.st_recv         = st_eff == pwrb_pkg::ST_RECV;
    stat.st_free         = st_eff == pwrb_pkg::ST_FREE;
    stat.kind_last       = ram_rdata.kind == pwrb_pkg::SEG_LAST ||
                           ram_rdata.kind == pwrb_pkg::SEG_ONLY;
    stat.dist_zero       = psn_dist == '0;
    stat.dist_small      = psn_dist < pwrb_pkg::seq_t'(pwrb_pkg::SLOTS);
    stat.cnt_nxt_eq_dist = (pwrb_pkg::seq_t'(cnt_r) + 1'b1) == psn_dist;
    stat.cnt_last        = cnt_r == pwrb_pkg::SLOT_BITS'(pwrb_pkg::SLOTS - 1);
    stat.cnt_eq_end      = cnt_r == end_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_final_r;
  assign out_tdata  = {6'b0, o_gseq_r, o_gap_r, o_done_r, o_hdl_r};

endmodule

FILE: src/psn_write_reassembly_buffer_top.sv
// channel | dir | tdata (low bit up)                        | tuser / tlast
// in_     | in  | queue_pair 24, seq_num 24, buf_handle 16  | tuser: command 2, seg_kind 2
// out_    | out | out_handle 16, write_done, gap_present,   | tuser: result_kind 4;
//         |     | gap_seq 24, 6 zero bits                   | tlast: is_final
//
// One item at a time; the slot memory has one read and one write port, and each slot
// visited takes a read state and a check state. A miss or a full table answers from
// the lookup; an add reads its slot (a duplicate ends there), then the slots skipped
// ahead of the expected PSN; a query reads one slot; a read, the run twice; a remove, all.
// Reset clears context and slot valid bits at once; no clearing pass.
// Results wait in an output register; a stalled out_ side holds the walk.
module psn_write_reassembly_buffer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // queue_pair, seq_num, buf_handle
  input  logic [3:0]  in_tuser,  // command, seg_kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // out_handle, write_done, gap_present, gap_seq
  output logic [3:0]  out_tuser, // result_kind
  output logic        out_tlast
);

  pwrb_pkg::ctl_cmd_t cmd;
  pwrb_pkg::dp_stat_t stat;

  pwrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pwrb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: dv/psn_write_reassembly_buffer_top_test.sv
`timescale 1ns / 100ps

module psn_write_reassembly_buffer_top_test;

  // one result item as seen on the out_ side
  typedef struct {
    pwrb_pkg::res_kind_t kind;
    pwrb_pkg::handle_t   handle;
    logic                last;
    logic                done;
    logic                gap;
    pwrb_pkg::seq_t      gap_seq;
  } pwrb_res_t;

  // scoreboard: holds a predicted copy of the context table
  class reassembly_scoreboard;
    bit                  valid[pwrb_pkg::CONTEXTS];
    pwrb_pkg::seq_t      qpn[pwrb_pkg::CONTEXTS];
    pwrb_pkg::seq_t      base_seq[pwrb_pkg::CONTEXTS];
    pwrb_pkg::seq_t      exp_psn[pwrb_pkg::CONTEXTS];
    bit                  complete[pwrb_pkg::CONTEXTS];
    logic [1:0]          status[pwrb_pkg::ENTRIES];
    pwrb_pkg::seg_kind_t skind[pwrb_pkg::ENTRIES];
    pwrb_pkg::handle_t   shandle[pwrb_pkg::ENTRIES];
    pwrb_res_t           pending[$];
    int                  errors;

    function void push(pwrb_pkg::res_kind_t k, pwrb_pkg::handle_t h, logic d, logic g,
                       pwrb_pkg::seq_t gs);
      pwrb_res_t r;
      r.kind = k; r.handle = h; r.last = 0; r.done = d; r.gap = g; r.gap_seq = gs;
      pending.push_back(r);
    endfunction

    function int lookup(pwrb_pkg::seq_t qp);
      for (int i = 0; i < pwrb_pkg::CONTEXTS; i++)
        if (valid[i] && qpn[i] == qp) return i;
      return -1;
    endfunction

    function int slot_at(int c, pwrb_pkg::seq_t psn);
      pwrb_pkg::seq_t d;
      d = psn - base_seq[c];
      return c * pwrb_pkg::SLOTS + (d % pwrb_pkg::SLOTS);
    endfunction

    // predict the results of one accepted input item
    function void note_input(pwrb_pkg::cmd_t cmd, pwrb_pkg::seq_t qp, pwrb_pkg::seq_t psn,
                             pwrb_pkg::seg_kind_t k, pwrb_pkg::handle_t h);
      int c;
      int s;
      pwrb_pkg::seq_t d;
      c = lookup(qp);
      if (cmd == pwrb_pkg::CMD_ADD) begin
        if (c < 0) begin
          for (int i = 0; i < pwrb_pkg::CONTEXTS; i++)
            if (!valid[i]) begin c = i; break; end
          if (c >= 0) begin
            valid[c] = 1; qpn[c] = qp; base_seq[c] = psn; exp_psn[c] = psn;
            complete[c] = 0;
            for (int i = 0; i < pwrb_pkg::SLOTS; i++) begin
              status[c*pwrb_pkg::SLOTS+i] = pwrb_pkg::ST_FREE;
              skind[c*pwrb_pkg::SLOTS+i] = pwrb_pkg::SEG_FIRST;
            end
          end
        end
        if (c < 0) push(pwrb_pkg::RES_FULL, 0, 0, 0, 0);
        else begin
          s = slot_at(c, psn);
          if (status[s] == pwrb_pkg::ST_RECV) push(pwrb_pkg::RES_DUP, h, 0, 0, 0);
          else begin
            shandle[s] = h; status[s] = pwrb_pkg::ST_RECV; skind[s] = k;
            d = psn - exp_psn[c];
            if (d == 0) exp_psn[c] = pwrb_pkg::seq_t'(exp_psn[c] + 1);
            else if (d < pwrb_pkg::SLOTS)
              for (int i = 0; i < d; i++)
                if (status[slot_at(c, pwrb_pkg::seq_t'(exp_psn[c] + i))] == pwrb_pkg::ST_FREE)
                  status[slot_at(c, pwrb_pkg::seq_t'(exp_psn[c] + i))] = pwrb_pkg::ST_WAIT;
            if (k == pwrb_pkg::SEG_LAST || k == pwrb_pkg::SEG_ONLY) complete[c] = 1;
            push(pwrb_pkg::RES_ACCEPTED, 0, 0, 0, 0);
          end
        end
      end else if (c < 0) push(pwrb_pkg::RES_NOT_FOUND, 0, 0, 0, 0);
      else if (cmd == pwrb_pkg::CMD_QUERY) begin
        s = slot_at(c, exp_psn[c]);
        push(pwrb_pkg::RES_QUERY, 0, complete[c], status[s] != pwrb_pkg::ST_RECV,
             status[s] != pwrb_pkg::ST_RECV ? exp_psn[c] : '0);
      end else if (cmd == pwrb_pkg::CMD_READ) begin
        int n;
        n = pending.size();
        for (int i = 0; i < pwrb_pkg::SLOTS; i++) begin
          s = c * pwrb_pkg::SLOTS + i;
          if (status[s] != pwrb_pkg::ST_RECV) begin
            while (pending.size() > n) void'(pending.pop_back());
            push(pwrb_pkg::RES_INCOMPLETE, 0, 0, 0, 0);
            break;
          end
          push(pwrb_pkg::RES_ORDERED, shandle[s], 0, 0, 0);
          if (skind[s] == pwrb_pkg::SEG_LAST || skind[s] == pwrb_pkg::SEG_ONLY) break;
        end
      end else begin
        for (int i = 0; i < pwrb_pkg::SLOTS; i++) begin
          s = c * pwrb_pkg::SLOTS + i;
          if (status[s] == pwrb_pkg::ST_RECV) push(pwrb_pkg::RES_RELEASED, shandle[s], 0, 0, 0);
          status[s] = pwrb_pkg::ST_FREE; skind[s] = pwrb_pkg::SEG_FIRST;
        end
        valid[c] = 0; qpn[c] = 0; base_seq[c] = 0; exp_psn[c] = 0; complete[c] = 0;
        push(pwrb_pkg::RES_REMOVED, 0, 0, 0, 0);
      end
      pending[pending.size()-1].last = 1;
    endfunction

    function void check_result(pwrb_res_t a);
      pwrb_res_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0d handle %h", $time, a.kind, a.handle);
        return;
      end
      e = pending.pop_front();
      if (a.kind !== e.kind || a.handle !== e.handle || a.last !== e.last ||
          a.done !== e.done || a.gap !== e.gap || a.gap_seq !== e.gap_seq) begin
        errors++;
        $display("%0t: mismatch exp kind %0d h %h last %b done %b gap %b seq %h",
                 $time, e.kind, e.handle, e.last, e.done, e.gap, e.gap_seq);
        $display("%0t:          act kind %0d h %h last %b done %b gap %b seq %h",
                 $time, a.kind, a.handle, a.last, a.done, a.gap, a.gap_seq);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  reassembly_scoreboard sb = new();
  int  send_idle_pct = 32;
  int  recv_idle_pct = 80;
  bit  hold_off = 0;
  int  quiet_cycles = 0;
  pwrb_pkg::seq_t qp_pool[12];

  psn_write_reassembly_buffer_top dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      pwrb_res_t r;
      r.kind = pwrb_pkg::res_kind_t'(out_tuser);
      r.handle = out_tdata[15:0];
      r.done = out_tdata[16];
      r.gap = out_tdata[17];
      r.gap_seq = out_tdata[41:18];
      r.last = out_tlast;
      sb.check_result(r);
    end
    out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("psn_write_reassembly_buffer_top regression: fail");
      $finish;
    end
  end

  // offer one item and wait until it is taken
  task automatic send_item(pwrb_pkg::cmd_t cmd, pwrb_pkg::seq_t qp, pwrb_pkg::seq_t psn,
                           pwrb_pkg::seg_kind_t k, pwrb_pkg::handle_t h);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1;
    in_tdata <= {h, psn, qp};
    in_tuser <= {k, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, qp, psn, k, h);
    in_tvalid <= 0;
    // the block takes no new item while it is busy with this one
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // mostly well-formed segmented writes with random order and noise
  task automatic random_phase(int n);
    pwrb_pkg::seq_t qp, base;
    int   len;
    int   sent;
    int   order[16];
    sent = 0;
    while (sent < n) begin
      qp = qp_pool[$urandom_range(11)];
      if ($urandom_range(9) < 7) begin
        base = ($urandom_range(3) == 0) ? pwrb_pkg::seq_t'(24'hFFFFF8 + $urandom_range(7)) :
               pwrb_pkg::seq_t'($urandom);
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) order[i] = i;
        if ($urandom_range(1)) order.shuffle();
        for (int i = 0; i < len; i++) begin
          pwrb_pkg::seg_kind_t k;
          k = (len == 1) ? pwrb_pkg::SEG_ONLY : (order[i] == 0) ? pwrb_pkg::SEG_FIRST :
              (order[i] == len - 1) ? pwrb_pkg::SEG_LAST : pwrb_pkg::SEG_MIDDLE;
          if ($urandom_range(15) == 0) k = pwrb_pkg::seg_kind_t'($urandom_range(3));
          send_item(pwrb_pkg::CMD_ADD, qp, pwrb_pkg::seq_t'(base + order[i]), k,
                    pwrb_pkg::handle_t'($urandom));
          sent++;
          if ($urandom_range(7) == 0) begin
            send_item(pwrb_pkg::CMD_ADD, qp, pwrb_pkg::seq_t'(base + order[i]), k,
                      pwrb_pkg::handle_t'($urandom));
            sent++;
          end
        end
        if ($urandom_range(1)) begin
          send_item(pwrb_pkg::CMD_QUERY, qp, pwrb_pkg::seq_t'($urandom), pwrb_pkg::SEG_FIRST,
                    pwrb_pkg::handle_t'($urandom));
          sent++;
        end
        send_item(pwrb_pkg::CMD_READ, qp, pwrb_pkg::seq_t'($urandom), pwrb_pkg::SEG_FIRST,
                  pwrb_pkg::handle_t'($urandom));
        sent++;
        if ($urandom_range(3) != 0) begin
          send_item(pwrb_pkg::CMD_REMOVE, qp, pwrb_pkg::seq_t'($urandom), pwrb_pkg::SEG_FIRST,
                    pwrb_pkg::handle_t'($urandom));
          sent++;
        end
      end else begin
        send_item(pwrb_pkg::cmd_t'($urandom_range(3)),
                  ($urandom_range(1) ? qp : pwrb_pkg::seq_t'($urandom)),
                  pwrb_pkg::seq_t'($urandom), pwrb_pkg::seg_kind_t'($urandom_range(3)),
                  pwrb_pkg::handle_t'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    foreach (qp_pool[i]) qp_pool[i] = pwrb_pkg::seq_t'($urandom);
    qp_pool[0] = 0;
    qp_pool[1] = 24'hFFFFFF;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: misses, extremes, gaps, duplicate, wrap, reads, removes, full table
    send_item(pwrb_pkg::CMD_QUERY, 24'h0, 0, pwrb_pkg::SEG_FIRST, 0);
    send_item(pwrb_pkg::CMD_READ, 24'hFFFFFF, 0, pwrb_pkg::SEG_FIRST, 0);
    send_item(pwrb_pkg::CMD_REMOVE, 24'h123456, 0, pwrb_pkg::SEG_FIRST, 0);
    send_item(pwrb_pkg::CMD_ADD, 24'h0, 24'hFFFFFE, pwrb_pkg::SEG_FIRST, 16'h0000);
    send_item(pwrb_pkg::CMD_ADD, 24'h0, 24'h000001, pwrb_pkg::SEG_LAST, 16'hFFFF);
    send_item(pwrb_pkg::CMD_QUERY, 24'h0, 0, pwrb_pkg::SEG_FIRST, 0);
    send_item(pwrb_pkg::CMD_READ, 24'h0, 0, pwrb_pkg::SEG_FIRST, 0);
    send_item(pwrb_pkg::CMD_ADD, 24'h0, 24'hFFFFFF, pwrb_pkg::SEG_MIDDLE, 16'hA5A5);
    send_item(pwrb_pkg::CMD_ADD, 24'h0, 24'hFFFFFF, pwrb_pkg::SEG_MIDDLE, 16'h5A5A);
    send_item(pwrb_pkg::CMD_ADD, 24'h0, 24'h000000, pwrb_pkg::SEG_MIDDLE, 16'h1234);
    send_item(pwrb_pkg::CMD_QUERY, 24'h0, 0, pwrb_pkg::SEG_FIRST, 0);
    send_item(pwrb_pkg::CMD_READ, 24'h0, 0, pwrb_pkg::SEG_FIRST, 0);
    send_item(pwrb_pkg::CMD_ADD, 24'h0, pwrb_pkg::seq_t'(24'hFFFFFE + 20), pwrb_pkg::SEG_ONLY,
              16'h0F0F);
    send_item(pwrb_pkg::CMD_REMOVE, 24'h0, 0, pwrb_pkg::SEG_FIRST, 0);
    for (int i = 0; i < pwrb_pkg::CONTEXTS + 1; i++)
      send_item(pwrb_pkg::CMD_ADD, pwrb_pkg::seq_t'(24'hFFFFFF - i), pwrb_pkg::seq_t'(i),
                pwrb_pkg::SEG_ONLY, pwrb_pkg::handle_t'(i));
    for (int i = 0; i < pwrb_pkg::CONTEXTS; i++)
      send_item(pwrb_pkg::CMD_REMOVE, pwrb_pkg::seq_t'(24'hFFFFFF - i), 0,
                pwrb_pkg::SEG_FIRST, 0);

    // fill up: receiver holds off while items keep coming
    hold_off = 1;
    fork
      begin repeat (400) @(posedge clk); hold_off = 0; end
      random_phase(20);
    join
    random_phase(90);
    send_idle_pct = 80; recv_idle_pct = 32;
    random_phase(100);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(100);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("psn_write_reassembly_buffer_top regression: pass");
    else
      $display("psn_write_reassembly_buffer_top regression: fail");
    $finish;
  end

endmodule
